// File: hdl/hru_pkg.sv
`default_nettype none
package hru_pkg;

	// Operation codes on func
	localparam logic [1:0] FN_INSERT = 2'd0;
	localparam logic [1:0] FN_MERGE  = 2'd1;
	localparam logic [1:0] FN_READ   = 2'd2;
	localparam logic [1:0] FN_CLEAR  = 2'd3;

	// Configuration port
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DW    = 4;
	localparam logic [CFG_IDX_W-1:0] REG_PRECISION = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MIXER     = 1'b1;
	localparam logic [3:0] PREC_RESET    = 4'd14;
	localparam int         MIN_PRECISION = 4;
	localparam logic [5:0] MAX_RANK      = 6'd61;

	// Mixer selection
	localparam logic [1:0] MIX_MURMUR = 2'd0;
	localparam logic [1:0] MIX_WANG   = 2'd1;
	localparam logic [1:0] MIX_RANHASH = 2'd2;
	localparam logic [1:0] MIX_NONE   = 2'd3;

	// Mixer micro-ops, one 64-bit step each (MUL runs as 32x32 partial products)
	typedef logic [2:0] op_t;
	localparam op_t OP_NOP  = 3'd0;
	localparam op_t OP_ADDC = 3'd1; // k + const
	localparam op_t OP_XSHR = 3'd2; // k ^ (k >> sa)
	localparam op_t OP_XSHL = 3'd3; // k ^ (k << sa)
	localparam op_t OP_MUL  = 3'd4; // k * const, mod 2^64
	localparam op_t OP_NADD = 3'd5; // ~k + (k << sa)
	localparam op_t OP_ADD3 = 3'd6; // k + (k << sa) + (k << sb)
	localparam op_t OP_ADDS = 3'd7; // k + (k << sa)

	// Constant slots
	localparam logic [2:0] C_ONE = 3'd0;
	localparam logic [2:0] C_M1  = 3'd1;
	localparam logic [2:0] C_M2  = 3'd2;
	localparam logic [2:0] C_R1  = 3'd3;
	localparam logic [2:0] C_R2  = 3'd4;
	localparam logic [2:0] C_R3  = 3'd5;

	typedef struct packed {
		op_t        op;
		logic [5:0] sa;
		logic [5:0] sb;
		logic [2:0] ci;
		logic       last;
	} instr_t;

	typedef struct packed {
		logic load;
		logic rank_s1;
		logic rank_s2;
		logic mem_rd;
		logic commit;
		logic clr_step;
		logic emit_clr;
	} cmd_t;

	typedef struct packed {
		logic hash_done;
		logic clr_last;
	} status_t;

	function automatic logic [63:0] mix_const(input logic [2:0] ci);
		logic [63:0] c;
		case (ci)
			C_ONE:   c = 64'd1;
			C_M1:    c = 64'hff51afd7ed558ccd;
			C_M2:    c = 64'hc4ceb9fe1a85ec53;
			C_R1:    c = 64'd3935559000370003845;
			C_R2:    c = 64'd2691343689449507681;
			C_R3:    c = 64'd4768777513237032717;
			default: c = 64'd0;
		endcase
		return c;
	endfunction

	function automatic instr_t mk(input op_t op, input logic [5:0] sa, input logic [5:0] sb,
			input logic [2:0] ci, input logic last);
		instr_t ins;
		ins.op   = op;
		ins.sa   = sa;
		ins.sb   = sb;
		ins.ci   = ci;
		ins.last = last;
		return ins;
	endfunction

	// Step programs for each mixer
	function automatic instr_t mix_prog(input logic [1:0] mixer, input logic [3:0] step);
		instr_t ins;
		ins = mk(OP_NOP, 6'd0, 6'd0, C_ONE, 1'b1);
		case ({mixer, step})
			{MIX_MURMUR, 4'd0}:  ins = mk(OP_ADDC, 6'd0,  6'd0, C_ONE, 1'b0);
			{MIX_MURMUR, 4'd1}:  ins = mk(OP_XSHR, 6'd33, 6'd0, C_ONE, 1'b0);
			{MIX_MURMUR, 4'd2}:  ins = mk(OP_MUL,  6'd0,  6'd0, C_M1,  1'b0);
			{MIX_MURMUR, 4'd3}:  ins = mk(OP_XSHR, 6'd33, 6'd0, C_ONE, 1'b0);
			{MIX_MURMUR, 4'd4}:  ins = mk(OP_MUL,  6'd0,  6'd0, C_M2,  1'b0);
			{MIX_MURMUR, 4'd5}:  ins = mk(OP_XSHR, 6'd33, 6'd0, C_ONE, 1'b1);
			{MIX_WANG, 4'd0}:    ins = mk(OP_NADD, 6'd21, 6'd0, C_ONE, 1'b0);
			{MIX_WANG, 4'd1}:    ins = mk(OP_XSHR, 6'd24, 6'd0, C_ONE, 1'b0);
			{MIX_WANG, 4'd2}:    ins = mk(OP_ADD3, 6'd3,  6'd8, C_ONE, 1'b0);
			{MIX_WANG, 4'd3}:    ins = mk(OP_XSHR, 6'd14, 6'd0, C_ONE, 1'b0);
			{MIX_WANG, 4'd4}:    ins = mk(OP_ADD3, 6'd2,  6'd4, C_ONE, 1'b0);
			{MIX_WANG, 4'd5}:    ins = mk(OP_XSHR, 6'd28, 6'd0, C_ONE, 1'b0);
			{MIX_WANG, 4'd6}:    ins = mk(OP_ADDS, 6'd31, 6'd0, C_ONE, 1'b1);
			{MIX_RANHASH, 4'd0}: ins = mk(OP_MUL,  6'd0,  6'd0, C_R1,  1'b0);
			{MIX_RANHASH, 4'd1}: ins = mk(OP_ADDC, 6'd0,  6'd0, C_R2,  1'b0);
			{MIX_RANHASH, 4'd2}: ins = mk(OP_XSHR, 6'd21, 6'd0, C_ONE, 1'b0);
			{MIX_RANHASH, 4'd3}: ins = mk(OP_XSHL, 6'd37, 6'd0, C_ONE, 1'b0);
			{MIX_RANHASH, 4'd4}: ins = mk(OP_XSHR, 6'd4,  6'd0, C_ONE, 1'b0);
			{MIX_RANHASH, 4'd5}: ins = mk(OP_MUL,  6'd0,  6'd0, C_R3,  1'b0);
			{MIX_RANHASH, 4'd6}: ins = mk(OP_XSHL, 6'd20, 6'd0, C_ONE, 1'b0);
			{MIX_RANHASH, 4'd7}: ins = mk(OP_XSHR, 6'd41, 6'd0, C_ONE, 1'b0);
			{MIX_RANHASH, 4'd8}: ins = mk(OP_XSHL, 6'd5,  6'd0, C_ONE, 1'b1);
			default: ;
		endcase
		return ins;
	endfunction

	// Leading zeros of one byte, 8 when zero
	function automatic logic [3:0] lzc8(input logic [7:0] b);
		logic [3:0] n;
		n = 4'd8;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				n = 4'(7 - i);
			end
		end
		return n;
	endfunction

endpackage
`default_nettype wire

// File: hdl/hru_mixer.sv
`default_nettype none
module hru_mixer import hru_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [1:0]  mixer,
	input  logic [63:0] item,
	output logic        done,
	output logic [63:0] hash
);

	localparam logic [1:0] PH_LAST = 2'd3;

	logic [63:0] k_q, acc_q, prod_q, k_d, c, prod;
	logic [31:0] mul_a, mul_b;
	logic [3:0]  step_q;
	logic [1:0]  phase_q;
	logic        run_q, done_q, step_end;
	instr_t      ins;

	assign ins = mix_prog(mixer, step_q);
	assign c   = mix_const(ins.ci);

	// one 32x32 partial product per cycle: LL, LH, HL
	assign mul_a = (phase_q == 2'd2) ? k_q[63:32] : k_q[31:0];
	assign mul_b = (phase_q == 2'd1) ? c[63:32] : c[31:0];
	assign prod  = 64'(mul_a) * 64'(mul_b);

	always_comb begin
		k_d      = k_q;
		step_end = 1'b1;
		unique case (ins.op)
			OP_NOP:  k_d = k_q;
			OP_ADDC: k_d = k_q + c;
			OP_XSHR: k_d = k_q ^ (k_q >> ins.sa);
			OP_XSHL: k_d = k_q ^ (k_q << ins.sa);
			OP_NADD: k_d = ~k_q + (k_q << ins.sa);
			OP_ADD3: k_d = k_q + (k_q << ins.sa) + (k_q << ins.sb);
			OP_ADDS: k_d = k_q + (k_q << ins.sa);
			OP_MUL: begin
				step_end = (phase_q == PH_LAST);
				k_d      = acc_q + {prod_q[31:0], 32'd0};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			done_q  <= 1'b0;
			step_q  <= '0;
			phase_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q   <= 1'b1;
				step_q  <= '0;
				phase_q <= '0;
			end else if (run_q) begin
				if (ins.op == OP_MUL) begin
					phase_q <= phase_q + 2'd1;
				end
				if (step_end) begin
					phase_q <= '0;
					step_q  <= step_q + 4'd1;
					if (ins.last) begin
						run_q  <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			k_q <= item;
		end else if (run_q) begin
			if (ins.op == OP_MUL) begin
				prod_q <= prod;
				if (phase_q == 2'd1) begin
					acc_q <= prod_q;
				end else if (phase_q == 2'd2) begin
					acc_q <= acc_q + {prod_q[31:0], 32'd0};
				end
			end
			if (step_end) begin
				k_q <= k_d;
			end
		end
	end

	assign done = done_q;
	assign hash = k_q;

endmodule
`default_nettype wire

// File: hdl/hru_ctrl.sv
`default_nettype none
module hru_ctrl import hru_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [1:0]           func,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  status_t              status,
	output cmd_t                 cmd,
	output logic                 busy
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_HASH   = 3'd1;
	localparam logic [2:0] S_RANK1  = 3'd2;
	localparam logic [2:0] S_RANK2  = 3'd3;
	localparam logic [2:0] S_READ   = 3'd4;
	localparam logic [2:0] S_COMMIT = 3'd5;
	localparam logic [2:0] S_CLEAR  = 3'd6;

	logic [2:0] state_q, state_d;
	logic       emit_q, emit_d, prec_wr;

	assign prec_wr = cfg_we && (cfg_index == REG_PRECISION);
	assign busy    = (state_q != S_IDLE) || prec_wr;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		emit_d  = emit_q;
		unique case (state_q)
			S_IDLE: begin
				if (prec_wr) begin
					state_d = S_CLEAR;
					emit_d  = 1'b0;
				end else if (start) begin
					cmd.load = 1'b1;
					unique case (func) inside
						FN_INSERT:         state_d = S_HASH;
						FN_MERGE, FN_READ: state_d = S_READ;
						FN_CLEAR: begin
							state_d = S_CLEAR;
							emit_d  = 1'b1;
						end
					endcase
				end
			end
			S_HASH: begin
				if (status.hash_done) begin
					state_d = S_RANK1;
				end
			end
			S_RANK1: begin
				cmd.rank_s1 = 1'b1;
				state_d     = S_RANK2;
			end
			S_RANK2: begin
				cmd.rank_s2 = 1'b1;
				state_d     = S_READ;
			end
			S_READ: begin
				cmd.mem_rd = 1'b1;
				state_d    = S_COMMIT;
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = S_IDLE;
			end
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				// a precision write restarts the sweep
				if (!prec_wr && status.clr_last) begin
					cmd.emit_clr = emit_q;
					emit_d       = 1'b0;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			emit_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			emit_q  <= emit_d;
		end
	end

endmodule
`default_nettype wire

// File: hdl/hru_datapath.sv
`default_nettype none
module hru_datapath import hru_pkg::*; #(
	parameter int MAX_PRECISION = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output status_t              status,
	input  logic [1:0]           func,
	input  logic [63:0]          item,
	input  logic [13:0]          reg_index,
	input  logic [5:0]           reg_value,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DW-1:0]    cfg_data,
	output logic                 done,
	output logic [13:0]          out_index,
	output logic [5:0]           out_value,
	output logic                 updated,
	output logic [14:0]          zero_registers,
	output logic [39:0]          observed
);

	localparam int AW      = MAX_PRECISION;
	localparam int DEPTH   = 1 << AW;
	localparam int PW      = $clog2(MAX_PRECISION + 1);
	localparam int ZW      = AW + 1;
	localparam int RESET_P = (MAX_PRECISION < 14) ? MAX_PRECISION : 14;
	localparam logic [ZW-1:0] ZC_RESET = ZW'(1 << RESET_P);

	function automatic logic [PW-1:0] eff_prec(input logic [3:0] pr);
		logic [PW-1:0] e;
		if (int'(pr) < MIN_PRECISION) begin
			e = PW'(MIN_PRECISION);
		end else if (int'(pr) > MAX_PRECISION) begin
			e = PW'(MAX_PRECISION);
		end else begin
			e = PW'(pr);
		end
		return e;
	endfunction

	logic [3:0]    prec_q;
	logic [1:0]    mixsel_q, func_q;
	logic [PW-1:0] p_eff, shamt;
	logic [AW-1:0] pmask, addr_q, idx_s1, clr_cnt_q, mem_wa;
	logic [5:0]    cap, val_sat, cand_q, rd_q, new_val, rank, mem_wd;
	logic [ZW-1:0] zc_q, zc_next;
	logic [39:0]   ins_q, ins_next;
	logic [63:0]   hash, masked;
	logic [3:0]    grp_cnt [8];
	logic [7:0]    grp_nz;
	logic [3:0]    cnt_s1 [8];
	logic [7:0]    nz_s1;
	logic [6:0]    lzc;
	logic          found, raise, mem_we, prec_wr, hash_done;
	logic [5:0]    mem [DEPTH];

	logic [AW-1:0] out_idx_q;
	logic [5:0]    out_val_q;
	logic          upd_q, done_q;
	logic [ZW-1:0] out_zc_q;
	logic [39:0]   out_obs_q;

	hru_mixer u_mixer (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.load && (func == FN_INSERT)),
		.mixer  (mixsel_q),
		.item   (item),
		.done   (hash_done),
		.hash   (hash)
	);

	assign prec_wr = cfg_we && (cfg_index == REG_PRECISION);
	assign p_eff   = eff_prec(prec_q);
	assign pmask   = ~({AW{1'b1}} << p_eff);
	assign cap     = 6'(7'd65 - 7'(p_eff));
	assign val_sat = (reg_value > cap) ? cap : reg_value;
	assign shamt   = PW'(AW) - p_eff;

	// rank: leading zeros below the index bits, one byte lane each
	assign masked = hash & ({64{1'b1}} >> p_eff);
	always_comb begin
		for (int g = 0; g < 8; g++) begin
			grp_cnt[g] = lzc8(masked[8*g +: 8]);
			grp_nz[g]  = |masked[8*g +: 8];
		end
	end

	always_comb begin
		found = 1'b0;
		lzc   = 7'd64;
		for (int i = 0; i < 8; i++) begin
			if (!found && nz_s1[7-i]) begin
				found = 1'b1;
				lzc   = 7'(8 * i) + 7'(cnt_s1[7-i]);
			end
		end
	end
	// zero remainder gives 65-p, the cap
	assign rank = 6'(lzc + 7'd1 - 7'(p_eff));

	assign raise    = cand_q > rd_q;
	assign new_val  = raise ? cand_q : rd_q;
	assign zc_next  = (raise && (rd_q == 6'd0) && (zc_q != '0)) ? zc_q - ZW'(1) : zc_q;
	assign ins_next = ((func_q == FN_INSERT) && (ins_q != '1)) ? ins_q + 40'd1 : ins_q;

	assign mem_we = cmd.clr_step || (cmd.commit && raise);
	assign mem_wa = cmd.clr_step ? clr_cnt_q : addr_q;
	assign mem_wd = cmd.clr_step ? 6'd0 : cand_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (cmd.mem_rd) begin
			rd_q <= mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prec_q    <= PREC_RESET;
			mixsel_q  <= MIX_MURMUR;
			zc_q      <= ZC_RESET;
			ins_q     <= '0;
			clr_cnt_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.commit || cmd.emit_clr;
			if (cfg_we && (cfg_index == REG_MIXER)) begin
				mixsel_q <= cfg_data[1:0];
			end
			if (prec_wr) begin
				prec_q    <= cfg_data;
				zc_q      <= ZW'(1) << eff_prec(cfg_data);
				clr_cnt_q <= '0;
			end else if (cmd.load && (func == FN_CLEAR)) begin
				zc_q      <= ZW'(1) << p_eff;
				clr_cnt_q <= '0;
			end else if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end else if (cmd.commit) begin
				zc_q  <= zc_next;
				ins_q <= ins_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			addr_q <= AW'(reg_index) & pmask;
			cand_q <= (func == FN_MERGE) ? val_sat : 6'd0;
		end
		if (cmd.rank_s1) begin
			idx_s1 <= AW'(hash[63 -: AW] >> shamt);
			nz_s1  <= grp_nz;
			for (int g = 0; g < 8; g++) begin
				cnt_s1[g] <= grp_cnt[g];
			end
		end
		if (cmd.rank_s2) begin
			addr_q <= idx_s1;
			cand_q <= rank;
		end
		if (cmd.commit) begin
			out_idx_q <= addr_q;
			out_val_q <= new_val;
			upd_q     <= raise;
			out_zc_q  <= zc_next;
			out_obs_q <= ins_next;
		end else if (cmd.emit_clr) begin
			out_idx_q <= '0;
			out_val_q <= 6'd0;
			upd_q     <= 1'b0;
			out_zc_q  <= zc_q;
			out_obs_q <= ins_q;
		end
	end

	assign status.hash_done = hash_done;
	assign status.clr_last  = (clr_cnt_q == '1);

	assign done           = done_q;
	assign out_index      = 14'(out_idx_q);
	assign out_value      = out_val_q;
	assign updated        = upd_q;
	assign zero_registers = 15'(out_zc_q);
	assign observed       = out_obs_q;

endmodule
`default_nettype wire

// File: hdl/hll_register_update.sv
// Dense HyperLogLog register engine, one operation at a time; results can't stall.
// Insert: the item is hashed by the selected mixer (murmur3, shift-add, ranhash or none),
//   then ranked, read and committed; each 64-bit multiply runs on one 32x32 multiplier.
// Merge/read: read, then commit. Clear op: done after a zeroing sweep of every RAM entry.
// busy drops as done rises, so a new command can be taken while done is high.
// Reset: async, then a zeroing sweep of every RAM entry (busy high); precision write too.
`default_nettype none
module hll_register_update import hru_pkg::*; #(
	parameter int MAX_PRECISION = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// command side: beat taken when start && !busy
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           func,
	input  logic [63:0]          item,
	input  logic [13:0]          reg_index,
	input  logic [5:0]           reg_value,
	// configuration: 0 precision, 1 mixer select
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DW-1:0]    cfg_data,
	// result side: one beat per command, valid for the single cycle done is high
	output logic                 done,
	output logic [13:0]          out_index,
	output logic [5:0]           out_value,
	output logic                 updated,
	output logic [14:0]          zero_registers,
	output logic [39:0]          observed
);

	cmd_t    cmd;
	status_t status;

	// Sequencer: idle -> hash wait -> rank (2 stages) -> RAM read -> commit,
	// or straight to the read for merge/read, or a RAM sweep for clear.
	hru_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.func      (func),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy)
	);

	// Rank RAM (2^MAX_PRECISION x 6), mixer, rank logic, counters and result regs.
	// The RAM has one write and one registered read port; a commit reads the
	// old rank the cycle before it writes the max back.
	hru_datapath #(
		.MAX_PRECISION (MAX_PRECISION)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.func           (func),
		.item           (item),
		.reg_index      (reg_index),
		.reg_value      (reg_value),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.done           (done),
		.out_index      (out_index),
		.out_value      (out_value),
		.updated        (updated),
		.zero_registers (zero_registers),
		.observed       (observed)
	);

endmodule
`default_nettype wire

// File: hdl/hru_checker.sv
`default_nettype none
module hru_checker import hru_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic                 done,
	input logic                 updated,
	input logic [5:0]           out_value
);

	// every accepted command keeps the block busy once it has been taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low right after an accepted command");

	// no result can follow a command in the next cycle
	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result strobe one cycle after accept");

	// the result beat coincides with the return to idle
	a_idle_at_done: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !(cfg_we && (cfg_index == REG_PRECISION))) |-> !busy)
		else $error("busy while a result is shown");

	// a raised register holds a nonzero rank no greater than MAX_RANK
	a_raise_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && updated) |-> ((out_value != 6'd0) && (out_value <= MAX_RANK)))
		else $error("raised register with bad rank");

endmodule

bind hll_register_update hru_checker u_hru_checker (.*);
`default_nettype wire
